@@ src/vhk_pkg.sv @@
// Package for the velocity half kick / speed limit unit.
// Word types, register indexes, reset values and pipeline depth constants.
// No dependencies.
`default_nettype none
package vhk_pkg;

    localparam int NUM_DIMS_DEF = 3;
    localparam int LANES        = 3;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd1;

    localparam logic [31:0] STEP_TIME_RST = 32'd8589935;
    localparam logic [30:0] MAX_SPEED_RST = 31'd655360;

    typedef logic [LANES-1:0][31:0] t_vel3;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] extra_x;
        logic signed [31:0] extra_y;
        logic signed [31:0] extra_z;
        logic        [31:0] inv_mass;
        logic        [2:0]  dim_mask;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               was_limited;
    } t_out_word;

endpackage
`default_nettype wire

@@ src/vhk_kick.sv @@
// Half kick front end: dt*inv_mass, force sum products, rounding and saturation.
// Three register stages. Depends on vhk_pkg.
`default_nettype none
module vhk_kick #(
    parameter int NUM_DIMS = vhk_pkg::NUM_DIMS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire vhk_pkg::t_in_word i_word,
    input  wire logic [31:0]       i_step_time,
    output logic                   o_valid,
    output vhk_pkg::t_vel3         o_vel
);
    import vhk_pkg::*;

    logic [LANES-1:0][31:0] in_vel;
    logic [LANES-1:0][32:0] in_sum;

    logic                   r1_v;
    logic [63:0]            r1_p;
    logic [LANES-1:0][31:0] r1_vel;
    logic [LANES-1:0][32:0] r1_sum;
    logic [2:0]             r1_mask;

    logic                   r2_v;
    logic [LANES-1:0][63:0] r2_lo;
    logic [LANES-1:0][63:0] r2_hi;
    logic [LANES-1:0]       r2_neg;
    logic [LANES-1:0]       r2_kick;
    logic [LANES-1:0][31:0] r2_vel;

    logic                   r3_v;
    t_vel3                  r3_vel;

    logic [LANES-1:0][32:0] n_mag;
    t_vel3                  n_vel;

    always_comb begin
        in_vel[0] = i_word.vel_x;
        in_vel[1] = i_word.vel_y;
        in_vel[2] = i_word.vel_z;
        in_sum[0] = 33'(signed'(i_word.force_x)) + 33'(signed'(i_word.extra_x));
        in_sum[1] = 33'(signed'(i_word.force_y)) + 33'(signed'(i_word.extra_y));
        in_sum[2] = 33'(signed'(i_word.force_z)) + 33'(signed'(i_word.extra_z));
    end

    always_comb begin
        for (int d = 0; d < LANES; d++) begin
            n_mag[d] = r1_sum[d][32] ? (33'd0 - r1_sum[d]) : r1_sum[d];
        end
    end

    always_comb begin
        logic [63:0] mid;
        logic [39:0] k;
        logic [41:0] vt;
        mid = '0;
        k   = '0;
        vt  = '0;
        for (int d = 0; d < LANES; d++) begin
            mid = r2_hi[d] + {32'd0, r2_lo[d][63:32]};
            k   = {1'b0, mid[63:25]} + {39'd0, mid[24]};
            vt  = r2_neg[d] ? ({{10{r2_vel[d][31]}}, r2_vel[d]} - {2'b00, k})
                            : ({{10{r2_vel[d][31]}}, r2_vel[d]} + {2'b00, k});
            if (!r2_kick[d]) begin
                n_vel[d] = r2_vel[d];
            end else if ($signed(vt) > 42'sd2147483647) begin
                n_vel[d] = 32'h7FFF_FFFF;
            end else if ($signed(vt) < -42'sd2147483648) begin
                n_vel[d] = 32'h8000_0000;
            end else begin
                n_vel[d] = vt[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= 64'(i_step_time) * 64'(i_word.inv_mass);
            r1_vel  <= in_vel;
            r1_sum  <= in_sum;
            r1_mask <= i_word.dim_mask;
            for (int d = 0; d < LANES; d++) begin
                r2_lo[d]   <= 64'(r1_p[31:0]) * 64'(n_mag[d]);
                r2_hi[d]   <= 64'(r1_p[63:32]) * 64'(n_mag[d]);
                r2_neg[d]  <= r1_sum[d][32];
                r2_kick[d] <= (d < NUM_DIMS) && r1_mask[d];
            end
            r2_vel <= r1_vel;
            r3_vel <= n_vel;
        end
    end

    assign o_valid = r3_v;
    assign o_vel   = r3_vel;

endmodule
`default_nettype wire

@@ src/vhk_sqrt.sv @@
// Pipelined integer square root of a 64 bit word, one root bit per stage.
// Carries a tag alongside the data. Depends on vhk_pkg.
`default_nettype none
module vhk_sqrt #(
    parameter int TAG_W = 97
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [63:0]      i_rad,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [31:0]           o_root,
    output logic [TAG_W-1:0]      o_tag
);
    import vhk_pkg::*;

    logic             r_v   [SQRT_STEPS];
    logic [63:0]      r_rad [SQRT_STEPS];
    logic [33:0]      r_rem [SQRT_STEPS];
    logic [31:0]      r_q   [SQRT_STEPS];
    logic [TAG_W-1:0] r_tag [SQRT_STEPS];

    logic [63:0]      n_rad [SQRT_STEPS];
    logic [33:0]      n_rem [SQRT_STEPS];
    logic [31:0]      n_q   [SQRT_STEPS];

    always_comb begin
        logic [63:0] s_rad;
        logic [33:0] s_rem;
        logic [31:0] s_q;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic [35:0] diff;
        s_rad  = '0;
        s_rem  = '0;
        s_q    = '0;
        rem_sh = '0;
        trial  = '0;
        diff   = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                s_rad = i_rad;
                s_rem = '0;
                s_q   = '0;
            end else begin
                s_rad = r_rad[k-1];
                s_rem = r_rem[k-1];
                s_q   = r_q[k-1];
            end
            rem_sh = {s_rem, s_rad[63:62]};
            trial  = {2'b00, s_q, 2'b01};
            diff   = rem_sh - trial;
            n_rad[k] = {s_rad[61:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem[k] = diff[33:0];
                n_q[k]   = {s_q[30:0], 1'b1};
            end else begin
                n_rem[k] = rem_sh[33:0];
                n_q[k]   = {s_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rad[k] <= n_rad[k];
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k > 0) begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_q[SQRT_STEPS-1];
    assign o_tag   = r_tag[SQRT_STEPS-1];

endmodule
`default_nettype wire

@@ src/vhk_div.sv @@
// Three lane pipelined restoring divider, 63 bit numerator by 32 bit divisor,
// one quotient bit per stage, 31 bit quotient. Depends on vhk_pkg.
`default_nettype none
module vhk_div #(
    parameter int TAG_W = 97
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [2:0][62:0]       i_num,
    input  wire logic [31:0]            i_den,
    input  wire logic [TAG_W-1:0]       i_tag,
    output logic                        o_valid,
    output logic [2:0][30:0]            o_quot,
    output logic [TAG_W-1:0]            o_tag
);
    import vhk_pkg::*;

    logic                   r_v    [DIV_STEPS];
    logic [LANES-1:0][31:0] r_rem  [DIV_STEPS];
    logic [LANES-1:0][30:0] r_rest [DIV_STEPS];
    logic [LANES-1:0][30:0] r_q    [DIV_STEPS];
    logic [31:0]            r_den  [DIV_STEPS];
    logic [TAG_W-1:0]       r_tag  [DIV_STEPS];

    logic [LANES-1:0][31:0] n_rem  [DIV_STEPS];
    logic [LANES-1:0][30:0] n_rest [DIV_STEPS];
    logic [LANES-1:0][30:0] n_q    [DIV_STEPS];

    always_comb begin
        logic [31:0] s_rem;
        logic [30:0] s_rest;
        logic [30:0] s_q;
        logic [31:0] s_den;
        logic [32:0] part;
        logic [32:0] diff;
        s_rem  = '0;
        s_rest = '0;
        s_q    = '0;
        s_den  = '0;
        part   = '0;
        diff   = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    s_rem  = i_num[l][62:31];
                    s_rest = i_num[l][30:0];
                    s_q    = '0;
                    s_den  = i_den;
                end else begin
                    s_rem  = r_rem[k-1][l];
                    s_rest = r_rest[k-1][l];
                    s_q    = r_q[k-1][l];
                    s_den  = r_den[k-1];
                end
                part = {s_rem, s_rest[30]};
                diff = part - {1'b0, s_den};
                n_rest[k][l] = {s_rest[29:0], 1'b0};
                if (part >= {1'b0, s_den}) begin
                    n_rem[k][l] = diff[31:0];
                    n_q[k][l]   = {s_q[29:0], 1'b1};
                end else begin
                    n_rem[k][l] = part[31:0];
                    n_q[k][l]   = {s_q[29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_rest[k] <= n_rest[k];
                r_q[k]    <= n_q[k];
                if (k > 0) begin
                    r_den[k] <= r_den[k-1];
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_q[DIV_STEPS-1];
    assign o_tag   = r_tag[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ src/velocity_half_kick_speed_limit_unit.sv @@
// Velocity half kick with speed limit, fully pipelined.
// Accepts one word per cycle while o_ready is high; the whole pipeline stalls while the skid entry is full.
// Depth is set by the 32 stage square root and the 31 stage divider.
// One skid entry behind the output register; o_ready drops only while it is full.
// Synchronous active low reset clears valid bits and loads register defaults.
// Depends on vhk_pkg, vhk_kick, vhk_sqrt, vhk_div.
`default_nettype none
module velocity_half_kick_speed_limit_unit #(
    parameter int NUM_DIMS = vhk_pkg::NUM_DIMS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [vhk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vhk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire vhk_pkg::t_in_word                i_data,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output vhk_pkg::t_out_word                    o_data
);
    import vhk_pkg::*;

    localparam int TAG_W = 1 + LANES * 32;

    logic [31:0] r_step_time;
    logic [30:0] r_max_speed;

    logic        en;
    logic        k_valid;
    t_vel3       k_vel;

    logic                   r4_v;
    logic [LANES-1:0][63:0] r4_sq;
    logic [61:0]            r4_ms2;
    t_vel3                  r4_vel;

    logic                   r5_v;
    logic [63:0]            r5_sum;
    logic                   r5_lim;
    t_vel3                  r5_vel;

    logic                   s_valid;
    logic [31:0]            s_root;
    logic [TAG_W-1:0]       s_tag;
    t_vel3                  s_vel;

    logic                   r6_v;
    logic [LANES-1:0][62:0] r6_num;
    logic [31:0]            r6_den;
    logic [TAG_W-1:0]       r6_tag;

    logic                   d_valid;
    logic [LANES-1:0][30:0] d_quot;
    logic [TAG_W-1:0]       d_tag;
    t_vel3                  d_vel;
    logic                   d_lim;

    logic                   r7_v;
    t_out_word              r7_word;
    t_vel3                  n_fin;

    logic                   r_out_v;
    t_out_word              r_out;
    logic                   r_skid_v;
    t_out_word              r_skid;

    logic [LANES-1:0][31:0] k_mag;
    logic [LANES-1:0][31:0] s_mag;
    logic [31:0]            a_mag_x;

    assign en      = !r_skid_v;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
            r_max_speed <= MAX_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEP_TIME: r_step_time <= i_cfg_data;
                REG_MAX_SPEED: r_max_speed <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    vhk_kick #(
        .NUM_DIMS (NUM_DIMS)
    ) u_kick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_word      (i_data),
        .i_step_time (r_step_time),
        .o_valid     (k_valid),
        .o_vel       (k_vel)
    );

    always_comb begin
        for (int d = 0; d < LANES; d++) begin
            k_mag[d] = k_vel[d][31] ? (32'd0 - k_vel[d]) : k_vel[d];
            s_mag[d] = s_vel[d][31] ? (32'd0 - s_vel[d]) : s_vel[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r4_v <= k_valid;
            r5_v <= r4_v;
            r6_v <= s_valid;
            r7_v <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < LANES; d++) begin
                r4_sq[d] <= (d < NUM_DIMS) ? (64'(k_mag[d]) * 64'(k_mag[d])) : 64'd0;
                r6_num[d] <= 63'(s_mag[d]) * 63'(r_max_speed);
            end
            r4_ms2 <= 62'(r_max_speed) * 62'(r_max_speed);
            r4_vel <= k_vel;
            r5_sum <= r4_sq[0] + r4_sq[1] + r4_sq[2];
            r5_lim <= (r4_sq[0] + r4_sq[1] + r4_sq[2]) > {2'b00, r4_ms2};
            r5_vel <= r4_vel;
            r6_den <= (s_root == 32'd0) ? 32'd1 : s_root;
            r6_tag <= s_tag;
            r7_word <= {n_fin[0], n_fin[1], n_fin[2], d_lim};
        end
    end

    vhk_sqrt #(
        .TAG_W (TAG_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rad   (r5_sum),
        .i_tag   ({r5_lim, r5_vel}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    assign s_vel = s_tag[LANES*32-1:0];

    vhk_div #(
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_tag   (r6_tag),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_tag   (d_tag)
    );

    assign d_vel = d_tag[LANES*32-1:0];
    assign d_lim = d_tag[TAG_W-1];

    always_comb begin
        for (int d = 0; d < LANES; d++) begin
            if (d_lim && (d < NUM_DIMS)) begin
                n_fin[d] = d_vel[d][31] ? (32'd0 - {1'b0, d_quot[d]}) : {1'b0, d_quot[d]};
            end else begin
                n_fin[d] = d_vel[d];
            end
        end
    end

    // output register plus one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r7_v && r_out_v && !i_ready) begin
            r_skid_v <= 1'b1;
        end else if (r7_v) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (r7_v) begin
            if (r_out_v && !i_ready) begin
                r_skid <= r7_word;
            end else begin
                r_out <= r7_word;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    assign a_mag_x = r_out.new_vel_x[31] ? (32'd0 - r_out.new_vel_x) : r_out.new_vel_x;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without output word");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_ready && r7_v))
        else $error("skid filled without a stalled output");

    a_limited_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.was_limited && $stable(r_max_speed))
            |-> (a_mag_x <= {1'b0, r_max_speed}))
        else $error("limited x component exceeds max speed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_v && !r_skid_v))
        else $error("output valid after reset");

endmodule
`default_nettype wire
